>>> rtl/mvnt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh vertex normal and tangent package
// Shared types and constants for the vertex normal and tangent block.
// ----------------------------------------------------------------------------
package mvnt_pkg;

   localparam int MAX_VERTICES_DEFAULT = 1024;
   localparam int UNIT_ONE             = 16384;

   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_TRIANGLE = 2'd1,
      OP_READ     = 2'd2
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [9:0]         vertex_index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] tex_u_in;
      logic [9:0]         corner_a;
      logic [9:0]         corner_b;
      logic [9:0]         corner_c;
   } req_type;

   typedef struct packed {
      logic [9:0]         out_vertex;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [15:0] tangent_x;
      logic signed [15:0] tangent_y;
      logic signed [15:0] tangent_z;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic signed [31:0] u;
   } store_type;

   typedef struct packed {
      logic signed [23:0] nx;
      logic signed [23:0] ny;
      logic signed [23:0] nz;
      logic signed [23:0] tx;
      logic signed [23:0] ty;
      logic signed [23:0] tz;
   } sum_type;

   typedef logic signed [63:0] wide_type;
   typedef logic signed [15:0] unit_type;

endpackage

>>> rtl/mvnt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh vertex RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module mvnt_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 4,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/mvnt_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh vertex vector normaliser
// Scales a signed vector to unit length in Q1.14 with a bit-serial square
// root and a bit-serial divider.
// ----------------------------------------------------------------------------
module mvnt_norm (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  mvnt_pkg::wide_type  vec_in [3],
   output logic                done,
   output mvnt_pkg::unit_type  res_out [3]
);

   import mvnt_pkg::*;

   typedef enum logic [2:0] {
      N_IDLE,
      N_SHIFT,
      N_SQUARE,
      N_SQRT,
      N_DIVINIT,
      N_DIV
   } state_type;

   state_type   state_ff;
   logic [63:0] mag_ff [3];
   logic        sign_ff [3];
   logic [1:0]  cnt_ff;
   logic [1:0]  comp_ff;
   logic [59:0] prod_ff;
   logic [63:0] acc_ff;
   logic [63:0] root_ff;
   logic [63:0] bit_ff;
   logic [47:0] rem_ff;
   logic [3:0]  k_ff;
   logic [14:0] q_ff;
   unit_type    res_ff [3];
   logic        done_ff;

   logic [1:0]  pick;
   logic [63:0] mag_pick;
   logic        wide;
   logic [63:0] sq_sum;
   logic [63:0] trial;
   logic [47:0] den_sh;
   logic        hit;
   logic [14:0] q_new;
   logic [15:0] q_ext;

   always_comb begin
      pick = (state_ff == N_SQUARE) ? cnt_ff : comp_ff;
      case (pick)
         2'd0:    mag_pick = mag_ff[0];
         2'd1:    mag_pick = mag_ff[1];
         default: mag_pick = mag_ff[2];
      endcase
      wide   = (mag_ff[0][63:30] != '0) || (mag_ff[1][63:30] != '0) ||
               (mag_ff[2][63:30] != '0);
      sq_sum = acc_ff + {4'b0, prod_ff};
      trial  = root_ff + bit_ff;
      den_sh = {15'b0, root_ff[31:0], 1'b0} << k_ff;
      hit    = rem_ff >= den_sh;
      q_new  = q_ff | (15'(hit) << k_ff);
      q_ext  = {1'b0, q_new};
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         case (state_ff)
            N_IDLE: begin
               if (start) begin
                  for (int i = 0; i < 3; i++) begin
                     sign_ff[i] <= vec_in[i][63];
                     mag_ff[i]  <= vec_in[i][63] ? 64'(-vec_in[i]) : 64'(vec_in[i]);
                  end
                  state_ff <= N_SHIFT;
               end
            end
            N_SHIFT: begin
               if (wide) begin
                  for (int i = 0; i < 3; i++) begin
                     mag_ff[i] <= mag_ff[i] >> 1;
                  end
               end else begin
                  cnt_ff   <= 2'd0;
                  acc_ff   <= '0;
                  state_ff <= N_SQUARE;
               end
            end
            N_SQUARE: begin
               if (cnt_ff != 2'd3) begin
                  prod_ff <= mag_pick[29:0] * mag_pick[29:0];
               end
               if (cnt_ff != 2'd0) begin
                  acc_ff <= sq_sum;
               end
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  if (sq_sum == '0) begin
                     for (int i = 0; i < 3; i++) begin
                        res_ff[i] <= '0;
                     end
                     done_ff  <= 1'b1;
                     state_ff <= N_IDLE;
                  end else begin
                     root_ff  <= '0;
                     bit_ff   <= 64'd1 << 62;
                     state_ff <= N_SQRT;
                  end
               end
            end
            N_SQRT: begin
               if (bit_ff == '0) begin
                  comp_ff  <= 2'd0;
                  state_ff <= N_DIVINIT;
               end else begin
                  if (acc_ff >= trial) begin
                     acc_ff  <= acc_ff - trial;
                     root_ff <= (root_ff >> 1) + bit_ff;
                  end else begin
                     root_ff <= root_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
               end
            end
            N_DIVINIT: begin
               rem_ff   <= ({18'b0, mag_pick[29:0]} << 15) + {16'b0, root_ff[31:0]};
               k_ff     <= 4'd14;
               q_ff     <= '0;
               state_ff <= N_DIV;
            end
            N_DIV: begin
               if (hit) begin
                  rem_ff <= rem_ff - den_sh;
               end
               q_ff <= q_new;
               if (k_ff == 4'd0) begin
                  res_ff[comp_ff] <= sign_ff[comp_ff] ? -q_ext : q_ext;
                  if (comp_ff == 2'd2) begin
                     done_ff  <= 1'b1;
                     state_ff <= N_IDLE;
                  end else begin
                     comp_ff  <= comp_ff + 2'd1;
                     state_ff <= N_DIVINIT;
                  end
               end else begin
                  k_ff <= k_ff - 4'd1;
               end
            end
            default: begin
               state_ff <= N_IDLE;
            end
         endcase
      end
   end

   assign done    = done_ff;
   assign res_out = res_ff;

endmodule

>>> rtl/mesh_vertex_normal_tangent_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh vertex normal and tangent accumulator
// After reset the block sweeps the sum memory to zero and holds busy high
// meanwhile. A load leaves busy low. A triangle holds busy high while its
// face normal is formed and normalised, for less time when its face is
// degenerate; in tangent mode a tangent pass follows, shorter for a zero
// tangent. A read holds busy high while the normal sum is normalised, for
// less time when the sum is zero; in tangent mode a tangent pass follows,
// shorter for a zero tangent. The result shows in the first cycle with
// busy low again. A read of a vertex at or above MAX_VERTICES answers in
// the next cycle and leaves busy low. Busy time depends on the edge shift
// and on the shared normaliser, whose shift stage and bit-serial square
// root run once for each vector and whose divider runs once for each
// component. One transaction is in flight at a time. Each result is shown
// for exactly one cycle with rsp_valid high; the receiver must take it
// then.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_tangent_top #(
   parameter int MAX_VERTICES = mvnt_pkg::MAX_VERTICES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mvnt_pkg::req_type req_data,
   output logic              rsp_valid,
   output mvnt_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);

   import mvnt_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_T_RA,
      S_T_RB,
      S_T_RC,
      S_T_EDGE,
      S_T_SHIFT,
      S_MUL,
      S_NGO,
      S_NWAIT,
      S_U_RD,
      S_U_WR,
      S_R_RD,
      S_R_CAP
   } state_type;

   typedef enum logic [1:0] {
      PH_TRI_N,
      PH_TRI_T,
      PH_RD_N,
      PH_RD_T
   } phase_type;

   state_type          state_ff;
   phase_type          phase_ff;
   logic               mode_ff;
   logic [AW-1:0]      clr_cnt_ff;
   req_type            req_ff;
   store_type          va_ff;
   store_type          vb_ff;
   logic [32:0]        emag_ff [6];
   logic               esign_ff [6];
   logic [32:0]        umag_ff [2];
   logic               usign_ff [2];
   logic signed [31:0] vec_a_ff [3];
   logic signed [31:0] vec_b_ff [3];
   logic signed [31:0] uv_ff [2];
   logic [2:0]         mul_cnt_ff;
   logic               kind_tan_ff;
   wide_type           prod_ff;
   wide_type           acc_ff [3];
   unit_type           fn_ff [3];
   unit_type           ft_ff [3];
   unit_type           un_ff [3];
   logic [1:0]         corner_cnt_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               store_we;
   logic [AW-1:0]      store_waddr;
   store_type          store_wdata;
   logic [AW-1:0]      store_raddr;
   store_type          store_rdata;
   logic               sum_we;
   logic [AW-1:0]      sum_waddr;
   sum_type            sum_wdata;
   logic [AW-1:0]      sum_raddr;
   sum_type            sum_rdata;
   sum_type            sum_upd;

   logic               norm_start;
   logic               norm_done;
   unit_type           norm_res [3];

   logic               vi_ok;
   logic               tri_ok;
   logic [9:0]         corner_sel;
   logic signed [32:0] ediff [6];
   logic signed [32:0] udiff [2];
   logic               e_wide;
   logic               u_wide;
   logic signed [31:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [63:0] mul_p;
   logic [2:0]         prev_cnt;

   function automatic logic signed [23:0] sat_add(logic signed [23:0] s,
                                                  logic signed [15:0] v);
      logic signed [24:0] t;
      t = 25'(s) + 25'(v);
      if (t > 25'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (t < -25'sd8388608) begin
         return 24'sh800000;
      end
      return 24'(t);
   endfunction

   function automatic logic signed [31:0] apply_sign(logic [32:0] m, logic s);
      logic signed [31:0] v;
      v = {2'b00, m[29:0]};
      return s ? -v : v;
   endfunction

   always_comb begin
      vi_ok  = 32'(req_data.vertex_index) < MAX_VERTICES;
      tri_ok = (32'(req_data.corner_a) < MAX_VERTICES) &&
               (32'(req_data.corner_b) < MAX_VERTICES) &&
               (32'(req_data.corner_c) < MAX_VERTICES);
      case (corner_cnt_ff)
         2'd0:    corner_sel = req_ff.corner_a;
         2'd1:    corner_sel = req_ff.corner_b;
         default: corner_sel = req_ff.corner_c;
      endcase

      ediff[0] = 33'(vb_ff.x) - 33'(va_ff.x);
      ediff[1] = 33'(vb_ff.y) - 33'(va_ff.y);
      ediff[2] = 33'(vb_ff.z) - 33'(va_ff.z);
      ediff[3] = 33'(store_rdata.x) - 33'(va_ff.x);
      ediff[4] = 33'(store_rdata.y) - 33'(va_ff.y);
      ediff[5] = 33'(store_rdata.z) - 33'(va_ff.z);
      udiff[0] = 33'(vb_ff.u) - 33'(va_ff.u);
      udiff[1] = 33'(store_rdata.u) - 33'(va_ff.u);

      e_wide = 1'b0;
      for (int i = 0; i < 6; i++) begin
         e_wide = e_wide | (emag_ff[i][32:30] != 3'b000);
      end
      u_wide = (umag_ff[0][32:30] != 3'b000) || (umag_ff[1][32:30] != 3'b000);

      if (kind_tan_ff) begin
         case (mul_cnt_ff)
            3'd0:    begin mul_a = vec_a_ff[0]; mul_b = uv_ff[1]; end
            3'd1:    begin mul_a = vec_b_ff[0]; mul_b = uv_ff[0]; end
            3'd2:    begin mul_a = vec_a_ff[1]; mul_b = uv_ff[1]; end
            3'd3:    begin mul_a = vec_b_ff[1]; mul_b = uv_ff[0]; end
            3'd4:    begin mul_a = vec_a_ff[2]; mul_b = uv_ff[1]; end
            3'd5:    begin mul_a = vec_b_ff[2]; mul_b = uv_ff[0]; end
            default: begin mul_a = vec_a_ff[0]; mul_b = uv_ff[0]; end
         endcase
      end else begin
         case (mul_cnt_ff)
            3'd0:    begin mul_a = vec_a_ff[1]; mul_b = vec_b_ff[2]; end
            3'd1:    begin mul_a = vec_a_ff[2]; mul_b = vec_b_ff[1]; end
            3'd2:    begin mul_a = vec_a_ff[2]; mul_b = vec_b_ff[0]; end
            3'd3:    begin mul_a = vec_a_ff[0]; mul_b = vec_b_ff[2]; end
            3'd4:    begin mul_a = vec_a_ff[0]; mul_b = vec_b_ff[1]; end
            3'd5:    begin mul_a = vec_a_ff[1]; mul_b = vec_b_ff[0]; end
            default: begin mul_a = vec_a_ff[0]; mul_b = vec_b_ff[0]; end
         endcase
      end
      mul_p    = mul_a * mul_b;
      prev_cnt = mul_cnt_ff - 3'd1;

      sum_upd    = sum_rdata;
      sum_upd.nx = sat_add(sum_rdata.nx, fn_ff[0]);
      sum_upd.ny = sat_add(sum_rdata.ny, fn_ff[1]);
      sum_upd.nz = sat_add(sum_rdata.nz, fn_ff[2]);
      if (mode_ff) begin
         sum_upd.tx = sat_add(sum_rdata.tx, ft_ff[0]);
         sum_upd.ty = sat_add(sum_rdata.ty, ft_ff[1]);
         sum_upd.tz = sat_add(sum_rdata.tz, ft_ff[2]);
      end
   end

   always_comb begin
      store_we    = 1'b0;
      store_waddr = AW'(req_data.vertex_index);
      store_wdata = '{x: req_data.pos_x, y: req_data.pos_y,
                      z: req_data.pos_z, u: req_data.tex_u_in};
      sum_we      = 1'b0;
      sum_waddr   = AW'(corner_sel);
      sum_wdata   = sum_upd;
      sum_raddr   = AW'(corner_sel);
      case (state_ff)
         S_T_RB:  store_raddr = AW'(req_ff.corner_b);
         S_T_RC:  store_raddr = AW'(req_ff.corner_c);
         default: store_raddr = AW'(req_ff.corner_a);
      endcase
      case (state_ff)
         S_CLEAR: begin
            sum_we    = 1'b1;
            sum_waddr = clr_cnt_ff;
            sum_wdata = '0;
         end
         S_IDLE: begin
            if (start && req_data.op == OP_LOAD && vi_ok) begin
               store_we  = 1'b1;
               sum_we    = 1'b1;
               sum_waddr = AW'(req_data.vertex_index);
               sum_wdata = '0;
            end
         end
         S_U_WR: begin
            sum_we = 1'b1;
         end
         S_R_RD: begin
            sum_raddr = AW'(req_ff.vertex_index);
         end
         default: begin
         end
      endcase
   end

   assign norm_start = (state_ff == S_NGO);

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
         mode_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
               if (clr_cnt_ff == AW'(MAX_VERTICES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_data;
                  case (req_data.op)
                     OP_TRIANGLE: begin
                        if (tri_ok) begin
                           state_ff <= S_T_RA;
                        end
                     end
                     OP_READ: begin
                        if (vi_ok) begin
                           state_ff <= S_R_RD;
                        end else begin
                           rsp_valid_ff      <= 1'b1;
                           rsp_ff            <= '0;
                           rsp_ff.out_vertex <= req_data.vertex_index;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_T_RA: state_ff <= S_T_RB;
            S_T_RB: begin
               va_ff    <= store_rdata;
               state_ff <= S_T_RC;
            end
            S_T_RC: begin
               vb_ff    <= store_rdata;
               state_ff <= S_T_EDGE;
            end
            S_T_EDGE: begin
               for (int i = 0; i < 6; i++) begin
                  esign_ff[i] <= ediff[i][32];
                  emag_ff[i]  <= ediff[i][32] ? 33'(-ediff[i]) : 33'(ediff[i]);
               end
               for (int i = 0; i < 2; i++) begin
                  usign_ff[i] <= udiff[i][32];
                  umag_ff[i]  <= udiff[i][32] ? 33'(-udiff[i]) : 33'(udiff[i]);
               end
               state_ff <= S_T_SHIFT;
            end
            S_T_SHIFT: begin
               if (e_wide) begin
                  for (int i = 0; i < 6; i++) begin
                     emag_ff[i] <= emag_ff[i] >> 1;
                  end
               end
               if (u_wide) begin
                  for (int i = 0; i < 2; i++) begin
                     umag_ff[i] <= umag_ff[i] >> 1;
                  end
               end
               if (!e_wide && !u_wide) begin
                  for (int i = 0; i < 3; i++) begin
                     vec_a_ff[i] <= apply_sign(emag_ff[i], esign_ff[i]);
                     vec_b_ff[i] <= apply_sign(emag_ff[i+3], esign_ff[i+3]);
                     acc_ff[i]   <= '0;
                  end
                  for (int i = 0; i < 2; i++) begin
                     uv_ff[i] <= apply_sign(umag_ff[i], usign_ff[i]);
                  end
                  mul_cnt_ff  <= '0;
                  kind_tan_ff <= 1'b0;
                  phase_ff    <= PH_TRI_N;
                  state_ff    <= S_MUL;
               end
            end
            S_MUL: begin
               if (mul_cnt_ff != 3'd6) begin
                  prod_ff <= mul_p;
               end
               if (mul_cnt_ff != 3'd0) begin
                  acc_ff[prev_cnt[2:1]] <= prev_cnt[0] ?
                     acc_ff[prev_cnt[2:1]] - prod_ff :
                     acc_ff[prev_cnt[2:1]] + prod_ff;
               end
               if (mul_cnt_ff == 3'd6) begin
                  state_ff <= S_NGO;
               end else begin
                  mul_cnt_ff <= mul_cnt_ff + 3'd1;
               end
            end
            S_NGO: state_ff <= S_NWAIT;
            S_NWAIT: begin
               if (norm_done) begin
                  case (phase_ff)
                     PH_TRI_N: begin
                        fn_ff <= norm_res;
                        if (mode_ff) begin
                           for (int i = 0; i < 3; i++) begin
                              acc_ff[i] <= '0;
                           end
                           mul_cnt_ff  <= '0;
                           kind_tan_ff <= 1'b1;
                           phase_ff    <= PH_TRI_T;
                           state_ff    <= S_MUL;
                        end else begin
                           corner_cnt_ff <= '0;
                           state_ff      <= S_U_RD;
                        end
                     end
                     PH_TRI_T: begin
                        ft_ff         <= norm_res;
                        corner_cnt_ff <= '0;
                        state_ff      <= S_U_RD;
                     end
                     PH_RD_N: begin
                        un_ff <= norm_res;
                        if (mode_ff) begin
                           for (int i = 0; i < 3; i++) begin
                              acc_ff[i] <= '0;
                           end
                           mul_cnt_ff  <= '0;
                           kind_tan_ff <= 1'b0;
                           phase_ff    <= PH_RD_T;
                           state_ff    <= S_MUL;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                           rsp_ff       <= '{out_vertex: req_ff.vertex_index,
                                             normal_x: norm_res[0],
                                             normal_y: norm_res[1],
                                             normal_z: norm_res[2],
                                             tangent_x: '0, tangent_y: '0,
                                             tangent_z: '0};
                           state_ff     <= S_IDLE;
                        end
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_ff       <= '{out_vertex: req_ff.vertex_index,
                                          normal_x: un_ff[0], normal_y: un_ff[1],
                                          normal_z: un_ff[2],
                                          tangent_x: norm_res[0],
                                          tangent_y: norm_res[1],
                                          tangent_z: norm_res[2]};
                        state_ff     <= S_IDLE;
                     end
                  endcase
               end
            end
            S_U_RD: state_ff <= S_U_WR;
            S_U_WR: begin
               corner_cnt_ff <= corner_cnt_ff + 2'd1;
               state_ff      <= (corner_cnt_ff == 2'd2) ? S_IDLE : S_U_RD;
            end
            S_R_RD: state_ff <= S_R_CAP;
            S_R_CAP: begin
               vec_a_ff[0] <= 32'(sum_rdata.nx);
               vec_a_ff[1] <= 32'(sum_rdata.ny);
               vec_a_ff[2] <= 32'(sum_rdata.nz);
               vec_b_ff[0] <= 32'(sum_rdata.tx);
               vec_b_ff[1] <= 32'(sum_rdata.ty);
               vec_b_ff[2] <= 32'(sum_rdata.tz);
               acc_ff[0]   <= 64'(sum_rdata.nx);
               acc_ff[1]   <= 64'(sum_rdata.ny);
               acc_ff[2]   <= 64'(sum_rdata.nz);
               phase_ff    <= PH_RD_N;
               state_ff    <= S_NGO;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   mvnt_ram #(
      .WIDTH ($bits(store_type)),
      .DEPTH (MAX_VERTICES)
   ) u_store_ram (
      .clock (clock),
      .we    (store_we),
      .waddr (store_waddr),
      .wdata (store_wdata),
      .raddr (store_raddr),
      .rdata (store_rdata)
   );

   mvnt_ram #(
      .WIDTH ($bits(sum_type)),
      .DEPTH (MAX_VERTICES)
   ) u_sum_ram (
      .clock (clock),
      .we    (sum_we),
      .waddr (sum_waddr),
      .wdata (sum_wdata),
      .raddr (sum_raddr),
      .rdata (sum_rdata)
   );

   mvnt_norm u_norm (
      .clock   (clock),
      .reset   (reset),
      .start   (norm_start),
      .vec_in  (acc_ff),
      .done    (norm_done),
      .res_out (norm_res)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/mvnt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh vertex normal and tangent checker
// Port-level checks on reset behaviour, result ranges, tangent-off results and read progress.
// ----------------------------------------------------------------------------
module mvnt_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input mvnt_pkg::req_type req_data,
   input logic              rsp_valid,
   input mvnt_pkg::rsp_type rsp_data,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic              csr_data
);

   import mvnt_pkg::*;

   logic mode_ff;
   logic req_seen;

   assign req_seen = start && !busy && (req_data.op == OP_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data;
      end
   end

   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");

   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.normal_x <= 16'(UNIT_ONE)) &&
                    (rsp_data.normal_x >= -16'(UNIT_ONE)) &&
                    (rsp_data.normal_y <= 16'(UNIT_ONE)) &&
                    (rsp_data.normal_y >= -16'(UNIT_ONE)) &&
                    (rsp_data.normal_z <= 16'(UNIT_ONE)) &&
                    (rsp_data.normal_z >= -16'(UNIT_ONE)))
      else $error("normal out of range");

   a_tangent_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !mode_ff) |-> (rsp_data.tangent_x == '0) &&
                                  (rsp_data.tangent_y == '0) &&
                                  (rsp_data.tangent_z == '0))
      else $error("tangent set with tangent mode off");

   a_read_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (req_seen && (32'(req_data.vertex_index) < 32'd3)) |=> busy || rsp_valid)
      else $error("read neither worked nor answered");

endmodule

bind mesh_vertex_normal_tangent_top mvnt_checker u_checker (.*);

>>> tb/sv/tb_mesh_vertex_normal_tangent_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal and tangent accumulator testbench
// Drives loads, triangles and reads through the command port and checks
// every read against an in-bench fixed-point predictor of the normal and
// tangent sums. Tangent mode is toggled between phases while the block is
// idle; input gaps come in random bursts.
// ----------------------------------------------------------------------------
module tb_mesh_vertex_normal_tangent_top;
   import mvnt_pkg::*;

   localparam int  N_VERT      = 1024;
   localparam int  ITEM_TARGET = 1350;
   localparam int  SETTLE      = 700;
   localparam longint LIMIT    = 3000000;

   typedef enum int {JOB_REQ, JOB_CFG, JOB_DRAIN, JOB_CALM} job_kind_type;
   typedef struct {
      job_kind_type kind;
      req_type      req;
      logic         mode;
   } job_type;
   typedef longint vec6_type[6];
   typedef longint vec3_type[3];

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data = 1'b0;

   job_type cmd_queue[$];
   rsp_type expected_normals[$];
   bit      loaded[N_VERT];
   int      item_count = 0;
   int      fail_count = 0;
   longint  cycle_count = 0;
   logic    took_req = 1'b0;
   logic    took_csr = 1'b0;
   int      gap_left = 0;
   int      gap_pct = 10;
   bit      idle_on = 1'b1;
   int      settle_cnt = 0;

   // predictor state
   logic    tangent_on = 1'b0;
   longint  pos_x[N_VERT], pos_y[N_VERT], pos_z[N_VERT], pos_u[N_VERT];
   longint  nsum[N_VERT][3], tsum[N_VERT][3];

   mesh_vertex_normal_tangent_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned magnitude(longint v);
      return v < 0 ? longint'(-v) : v;
   endfunction

   // shift all components together until each magnitude is below 2^30
   function automatic void squeeze(inout vec6_type v);
      longint unsigned m;
      int s;
      m = 0;
      s = 0;
      foreach (v[i]) if (magnitude(v[i]) > m) m = magnitude(v[i]);
      while ((m >> s) >= (64'd1 << 30)) s++;
      foreach (v[i]) v[i] = v[i] < 0 ? -longint'(magnitude(v[i]) >> s)
                                     : longint'(magnitude(v[i]) >> s);
   endfunction

   function automatic longint unsigned root64(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic vec3_type unit_vec(vec3_type in);
      vec6_type c;
      vec3_type out;
      longint unsigned sum, len, q;
      c = '{in[0], in[1], in[2], 0, 0, 0};
      squeeze(c);
      sum = 0;
      for (int i = 0; i < 3; i++) sum += magnitude(c[i]) * magnitude(c[i]);
      out = '{0, 0, 0};
      if (sum == 0) return out;
      len = root64(sum);
      for (int i = 0; i < 3; i++) begin
         q = (magnitude(c[i]) * 32768 + len) / (2 * len);
         out[i] = c[i] < 0 ? -longint'(q) : longint'(q);
      end
      return out;
   endfunction

   function automatic vec3_type cross_prod(vec3_type a, vec3_type b);
      vec3_type r;
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
      return r;
   endfunction

   function automatic longint sat24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic void accumulate_triangle(int a, int b, int c);
      vec6_type e, uv;
      vec3_type fn, ft, t, ea, eb;
      int corner[3];
      e = '{pos_x[b] - pos_x[a], pos_y[b] - pos_y[a], pos_z[b] - pos_z[a],
            pos_x[c] - pos_x[a], pos_y[c] - pos_y[a], pos_z[c] - pos_z[a]};
      squeeze(e);
      ea = '{e[0], e[1], e[2]};
      eb = '{e[3], e[4], e[5]};
      fn = unit_vec(cross_prod(ea, eb));
      ft = '{0, 0, 0};
      if (tangent_on) begin
         uv = '{pos_u[b] - pos_u[a], pos_u[c] - pos_u[a], 0, 0, 0, 0};
         squeeze(uv);
         for (int j = 0; j < 3; j++) t[j] = e[j] * uv[1] - e[3 + j] * uv[0];
         ft = unit_vec(t);
      end
      corner = '{a, b, c};
      foreach (corner[k]) for (int j = 0; j < 3; j++) begin
         nsum[corner[k]][j] = sat24(nsum[corner[k]][j] + fn[j]);
         if (tangent_on) tsum[corner[k]][j] = sat24(tsum[corner[k]][j] + ft[j]);
      end
   endfunction

   function automatic void predict_mesh_op(req_type r);
      vec3_type un, ut;
      rsp_type x;
      int v;
      v = r.vertex_index;
      case (r.op)
         OP_LOAD: begin
            pos_x[v] = r.pos_x;
            pos_y[v] = r.pos_y;
            pos_z[v] = r.pos_z;
            pos_u[v] = r.tex_u_in;
            nsum[v] = '{0, 0, 0};
            tsum[v] = '{0, 0, 0};
         end
         OP_TRIANGLE: accumulate_triangle(r.corner_a, r.corner_b, r.corner_c);
         OP_READ: begin
            un = unit_vec(nsum[v]);
            ut = '{0, 0, 0};
            if (tangent_on) ut = unit_vec(cross_prod(nsum[v], tsum[v]));
            x.out_vertex = r.vertex_index;
            x.normal_x  = un[0][15:0];
            x.normal_y  = un[1][15:0];
            x.normal_z  = un[2][15:0];
            x.tangent_x = ut[0][15:0];
            x.tangent_y = ut[1][15:0];
            x.tangent_z = ut[2][15:0];
            expected_normals.insert(expected_normals.size(), x);
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
         fail_count++;
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name,
                  $signed(exp_v), $signed(act_v));
      end
   endfunction

   // sample transactions and check results
   always @(posedge clock) begin : monitor
      rsp_type e;
      cycle_count++;
      if (cycle_count > LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else if (!reset) begin
         if (rsp_valid) begin
            if (expected_normals.size() == 0) begin
               fail_count++;
               $display("%0t unexpected result: expected none actual %h", $time, rsp_data);
            end else begin
               e = expected_normals.pop_front();
               check_field("out_vertex", 16'(e.out_vertex), 16'(rsp_data.out_vertex));
               check_field("normal_x", e.normal_x, rsp_data.normal_x);
               check_field("normal_y", e.normal_y, rsp_data.normal_y);
               check_field("normal_z", e.normal_z, rsp_data.normal_z);
               check_field("tangent_x", e.tangent_x, rsp_data.tangent_x);
               check_field("tangent_y", e.tangent_y, rsp_data.tangent_y);
               check_field("tangent_z", e.tangent_z, rsp_data.tangent_z);
            end
         end
         if (start && !busy) predict_mesh_op(req_data);
         if (csr_valid && csr_ready) tangent_on = csr_data;
      end
      took_req <= !reset && start && !busy;
      took_csr <= !reset && csr_valid && csr_ready;
   end

   // drive queued transactions
   always @(negedge clock) begin : driver
      logic nstart, ncsr;
      job_type j;
      nstart = start;
      ncsr = csr_valid;
      if (took_req) nstart = 1'b0;
      if (took_csr) ncsr = 1'b0;
      if (!reset && !nstart && !ncsr) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (cmd_queue.size() > 0) begin
            j = cmd_queue[0];
            case (j.kind)
               JOB_REQ: begin
                  req_data <= j.req;
                  nstart = 1'b1;
                  void'(cmd_queue.pop_front());
                  if (idle_on && $urandom_range(0, 99) < gap_pct)
                     gap_left = $urandom_range(1, 18);
               end
               JOB_CFG: begin
                  if (expected_normals.size() == 0 && !busy) begin
                     if (settle_cnt >= SETTLE) begin
                        csr_data <= j.mode;
                        ncsr = 1'b1;
                        settle_cnt = 0;
                        gap_pct = $urandom_range(0, 2) * 15;
                        void'(cmd_queue.pop_front());
                     end else begin
                        settle_cnt++;
                     end
                  end else begin
                     settle_cnt = 0;
                  end
               end
               JOB_DRAIN: if (expected_normals.size() == 0) void'(cmd_queue.pop_front());
               JOB_CALM: begin
                  idle_on = 1'b0;
                  void'(cmd_queue.pop_front());
               end
            endcase
         end
      end
      start <= nstart;
      csr_valid <= ncsr;
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 131072)) - 65536);
         2: return 32'($signed($urandom_range(0, 33554432)) - 16777216);
         3: case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0;
               default: return 32'hffff_ffff;
            endcase
         default: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
      endcase
   endfunction

   function automatic req_type noise_req(op_type op);
      req_type r;
      r.op = op;
      r.vertex_index = $urandom;
      r.pos_x = $urandom;
      r.pos_y = $urandom;
      r.pos_z = $urandom;
      r.tex_u_in = $urandom;
      r.corner_a = $urandom;
      r.corner_b = $urandom;
      r.corner_c = $urandom;
      return r;
   endfunction

   function automatic void push_req(req_type r);
      job_type j;
      j.kind = JOB_REQ;
      j.req = r;
      j.mode = 1'b0;
      cmd_queue.insert(cmd_queue.size(), j);
      if (r.op != op_type'(2'd3)) item_count++;
   endfunction

   function automatic void push_ctl(job_kind_type k, logic m);
      job_type j;
      j.kind = k;
      j.req = '0;
      j.mode = m;
      cmd_queue.insert(cmd_queue.size(), j);
   endfunction

   function automatic void push_load(int v, logic [31:0] x, logic [31:0] y,
                                     logic [31:0] z, logic [31:0] u);
      req_type r;
      r = noise_req(OP_LOAD);
      r.vertex_index = v;
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      r.tex_u_in = u;
      loaded[v] = 1'b1;
      push_req(r);
   endfunction

   function automatic void push_tri(int a, int b, int c);
      req_type r;
      r = noise_req(OP_TRIANGLE);
      r.corner_a = a;
      r.corner_b = b;
      r.corner_c = c;
      push_req(r);
   endfunction

   function automatic void push_read(int v);
      req_type r;
      r = noise_req(OP_READ);
      r.vertex_index = v;
      push_req(r);
   endfunction

   function automatic int any_loaded();
      int v;
      do v = $urandom_range(0, N_VERT - 1); while (!loaded[v]);
      return v;
   endfunction

   // small mesh: load a handful of vertices, add triangles, read them back
   function automatic void push_mesh();
      int ids[8];
      int n;
      n = $urandom_range(3, 8);
      for (int i = 0; i < n; i++) begin
         ids[i] = $urandom_range(0, N_VERT - 1);
         push_load(ids[i], pick_coord(), pick_coord(), pick_coord(), pick_coord());
      end
      repeat ($urandom_range(1, 2 * n))
         push_tri(ids[$urandom_range(0, n - 1)], ids[$urandom_range(0, n - 1)],
                  ids[$urandom_range(0, n - 1)]);
      repeat ($urandom_range(1, n)) push_read(ids[$urandom_range(0, n - 1)]);
   endfunction

   function automatic void push_noise();
      case ($urandom_range(0, 4))
         0: push_req(noise_req(op_type'(2'd3)));
         1: push_read($urandom_range(0, N_VERT - 1));
         2: push_tri(any_loaded(), any_loaded(), any_loaded());
         3: push_load($urandom_range(0, N_VERT - 1), pick_coord(), pick_coord(),
                      pick_coord(), pick_coord());
         default: push_read(any_loaded());
      endcase
   endfunction

   initial begin
      int phase;
      logic m;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      push_ctl(JOB_CFG, 1'b0);
      push_load(0, 32'h0, 32'h0, 32'h0, 32'h0);
      push_load(1, 32'h7fff_ffff, 32'h0, 32'h0, 32'h7fff_ffff);
      push_load(2, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
      push_load(1023, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      push_tri(0, 1, 2);
      push_tri(0, 0, 1);
      push_tri(1, 2, 1023);
      push_req(noise_req(op_type'(2'd3)));
      push_read(0);
      push_read(1);
      push_read(1023);
      push_read(512);
      push_ctl(JOB_CFG, 1'b1);
      push_tri(0, 1, 2);
      push_tri(2, 1, 0);
      push_read(0);
      push_read(2);
      push_tri(1023, 1023, 1023);
      push_read(1023);
      push_load(0, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
      push_read(0);

      // saturate the sums with many identical faces
      push_load(600, 32'h0, 32'h0, 32'h0, 32'h0);
      push_load(601, 32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000);
      push_load(602, 32'h0, 32'h0001_0000, 32'h0, 32'h0);
      repeat (520) push_tri(600, 601, 602);
      push_read(600);
      push_read(601);

      phase = 0;
      m = 1'b0;
      while (item_count < ITEM_TARGET) begin
         if (item_count > 700 + 120 * phase) begin
            phase++;
            push_ctl(JOB_CFG, m);
            m = ~m;
            if (phase == 2) push_ctl(JOB_DRAIN, 1'b0);
            if (phase == 4) push_ctl(JOB_CALM, 1'b0);
         end
         if ($urandom_range(0, 99) < 80) push_mesh();
         else push_noise();
      end

      wait (cmd_queue.size() == 0 && !start && !csr_valid && expected_normals.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (expected_normals.size() != 0) begin
         fail_count++;
         $display("%0t missing result: expected %h actual none", $time, expected_normals[0]);
      end
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> mesh_vertex_normal_tangent_top.f
rtl/mvnt_pkg.sv
rtl/mvnt_ram.sv
rtl/mvnt_norm.sv
rtl/mesh_vertex_normal_tangent_top.sv
rtl/mvnt_checker.sv
tb/sv/tb_mesh_vertex_normal_tangent_top.sv
